[hdl/cfbt_pkg.sv]
// ----------------------------------------------------------------------------
// cfbt_pkg
// shared types and constants of the calibrated factor table
// ----------------------------------------------------------------------------
package cfbt_pkg;

    localparam int DATA_W = 32;
    localparam int KEY_W  = 10;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CAL   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_PHASE = 2'd3
    } t_status;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_ADD_SCN = 11'b000_0000_0010,
        S_ADD_DIV = 11'b000_0000_0100,
        S_Q_GSCN  = 11'b000_0000_1000,
        S_Q_PRD   = 11'b000_0001_0000,
        S_Q_PCMP  = 11'b000_0010_0000,
        S_Q_GEND  = 11'b000_0100_0000,
        S_B_DIV   = 11'b000_1000_0000,
        S_B_MUL   = 11'b001_0000_0000,
        S_B_ADD   = 11'b010_0000_0000,
        S_B_WAIT  = 11'b100_0000_0000
    } t_state;

endpackage

[hdl/calibrated_factor_bilinear_table_top.sv]
// ----------------------------------------------------------------------------
// calibrated_factor_bilinear_table_top
// calibration table of scale factors with two-dimensional linear lookup
// ----------------------------------------------------------------------------
// usage
// - a request is taken when start is high and busy is low; i_cmd picks add
//   point, calibrate or query; every request gives exactly one result
// - the result shows on o_factor_out / o_status for one cycle with o_valid
//   high; the receiver cannot stall, so it must take it in that cycle
// - add: group lookup walks the stored keys, one per cycle, then the shared
//   divider forms measured / estimated
// - calibrate: sets the phase flag only
// - query: walks the stored group keys, then the points of each of the
//   (up to two) bracketing groups, and does up to three blends on the
//   shared divider and multiplier
// - points are kept in arrival order; a query picks the bracketing points
//   by scanning, which gives the same neighbors as a stable sort
// - busy stays high from acceptance until the result strobe; a new request
//   may be taken in the strobe cycle
// - reset clears group count, fill counts and the calibrated flag; keys and
//   point storage are written before they are read and need no clearing
// ----------------------------------------------------------------------------
module calibrated_factor_bilinear_table_top
    import cfbt_pkg::*;
#(
    parameter int MAX_GROUPS = 16,
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_cmd,
    input  logic [KEY_W-1:0]  i_input_count,
    input  logic [DATA_W-1:0] i_size_value,
    input  logic [DATA_W-1:0] i_measured_power,
    input  logic [DATA_W-1:0] i_estimated_power,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_factor_out,
    output logic [1:0]        o_status
);

    localparam int DEPTH = MAX_GROUPS * MAX_POINTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int GIW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GCW   = $clog2(MAX_GROUPS + 1);
    localparam int PCW   = $clog2(MAX_POINTS + 1);
    localparam int DW    = DATA_W + FRAC_BITS;
    localparam int PERCW = FRAC_BITS + 1;
    localparam int PW    = DATA_W + PERCW;
    localparam int RW    = 2 * DATA_W;

    // control
    t_state            r_state, n_state;
    logic              r_cal, n_cal;
    logic [GCW-1:0]    r_total, n_total;
    logic              r_ovalid, n_ovalid;
    logic [DATA_W-1:0] r_factor, n_factor;
    logic [1:0]        r_status, n_status;

    // group store
    logic [KEY_W-1:0]  r_key  [MAX_GROUPS];
    logic [PCW-1:0]    r_fill [MAX_GROUPS];
    logic              key_we, fill_we;
    logic [GIW-1:0]    grp_wi;
    logic [KEY_W-1:0]  key_wd;
    logic [PCW-1:0]    fill_wd;

    // latched request
    logic [KEY_W-1:0]  r_n;
    logic [DATA_W-1:0] r_s, r_m, r_e;

    // scan counters
    logic [GCW-1:0]    r_gi, n_gi;
    logic [PCW-1:0]    r_pi, n_pi;
    logic [GIW-1:0]    r_cur, n_cur;
    logic              r_second, n_second;

    // bracketing groups
    logic              r_lo_has, n_lo_has, r_hi_has, n_hi_has;
    logic [GIW-1:0]    r_lo_idx, n_lo_idx, r_hi_idx, n_hi_idx;
    logic [KEY_W-1:0]  r_lo_key, n_lo_key, r_hi_key, n_hi_key;

    // bracketing points of the current group
    logic              r_lhas, n_lhas, r_uhas, n_uhas;
    logic [DATA_W-1:0] r_ls, n_ls, r_lf, n_lf, r_us, n_us, r_uf, n_uf;

    // blend datapath
    logic              r_outer, n_outer;
    logic [DATA_W-1:0] r_fl, n_fl, r_fu, n_fu;
    logic [DATA_W-1:0] r_diff, n_diff;
    logic              r_up, n_up;
    logic [PW-1:0]     r_prod, n_prod;
    logic [DATA_W-1:0] r_vlo, n_vlo;
    logic [PW-1:0]     rnd_sum;
    logic [DATA_W-1:0] blend_res;

    // shared divider
    logic              div_start, div_done;
    logic [DW-1:0]     div_dvd, div_quot;
    logic [DATA_W-1:0] div_dvs;

    // point ram
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [RW-1:0]     ram_wdata, ram_rdata;
    logic [DATA_W-1:0] rd_size, rd_fac;

    // group value hand-off
    logic              gv_fire;
    logic [DATA_W-1:0] gv_val;
    logic [GIW-1:0]    gi_ix;
    logic [PCW-1:0]    cur_fill;

    cfbt_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    cfbt_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_size  = ram_rdata[RW-1:DATA_W];
    assign rd_fac   = ram_rdata[DATA_W-1:0];
    assign gi_ix    = r_gi[GIW-1:0];
    assign cur_fill = r_fill[r_cur];

    // rounding of the scaled difference
    assign rnd_sum   = r_prod + (PW'(1) << (FRAC_BITS - 1));
    assign blend_res = r_up ? (r_fl + rnd_sum[FRAC_BITS +: DATA_W])
                            : (r_fl - rnd_sum[FRAC_BITS +: DATA_W]);

    always_comb begin
        n_state  = r_state;
        n_cal    = r_cal;
        n_total  = r_total;
        n_ovalid = 1'b0;
        n_factor = r_factor;
        n_status = r_status;
        n_gi     = r_gi;
        n_pi     = r_pi;
        n_cur    = r_cur;
        n_second = r_second;
        n_lo_has = r_lo_has;
        n_lo_idx = r_lo_idx;
        n_lo_key = r_lo_key;
        n_hi_has = r_hi_has;
        n_hi_idx = r_hi_idx;
        n_hi_key = r_hi_key;
        n_lhas   = r_lhas;
        n_ls     = r_ls;
        n_lf     = r_lf;
        n_uhas   = r_uhas;
        n_us     = r_us;
        n_uf     = r_uf;
        n_outer  = r_outer;
        n_fl     = r_fl;
        n_fu     = r_fu;
        n_diff   = r_diff;
        n_up     = r_up;
        n_prod   = r_prod;
        n_vlo    = r_vlo;
        key_we   = 1'b0;
        fill_we  = 1'b0;
        grp_wi   = gi_ix;
        key_wd   = r_n;
        fill_wd  = '0;
        div_start = 1'b0;
        div_dvd  = {r_m, FRAC_BITS'(0)};
        div_dvs  = r_e;
        ram_we   = 1'b0;
        ram_waddr = AW'(int'(r_gi[GIW-1:0]) * MAX_POINTS + int'(r_fill[gi_ix]));
        ram_wdata = {r_s, r_e};
        ram_raddr = AW'(int'(r_cur) * MAX_POINTS + int'(r_pi));
        gv_fire  = 1'b0;
        gv_val   = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_gi     = '0;
                    n_lo_has = 1'b0;
                    n_hi_has = 1'b0;
                    case (i_cmd)
                        CMD_ADD: begin
                            if (r_cal) begin
                                n_state = S_B_WAIT;
                                n_status = ST_PHASE;
                            end else if (i_input_count == '0) begin
                                n_state = S_B_WAIT;
                                n_status = ST_OK;
                            end else begin
                                n_state = S_ADD_SCN;
                            end
                        end
                        CMD_CAL: begin
                            n_cal    = 1'b1;
                            n_state  = S_B_WAIT;
                            n_status = ST_OK;
                        end
                        CMD_QUERY: begin
                            if (!r_cal) begin
                                n_state  = S_B_WAIT;
                                n_status = ST_PHASE;
                            end else begin
                                n_state = S_Q_GSCN;
                            end
                        end
                        default: begin
                            n_state  = S_B_WAIT;
                            n_status = ST_OK;
                        end
                    endcase
                    n_factor = '0;
                end
            end

            // hold state so every plain result leaves through one path
            S_B_WAIT: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end

            S_ADD_SCN: begin
                if (r_gi == r_total) begin
                    if (r_total == GCW'(MAX_GROUPS)) begin
                        n_status = ST_FULL;
                        n_ovalid = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        key_we    = 1'b1;
                        fill_we   = 1'b1;
                        fill_wd   = '0;
                        n_total   = r_total + 1'b1;
                        div_start = 1'b1;
                        n_state   = S_ADD_DIV;
                    end
                end else if (r_key[gi_ix] == r_n) begin
                    if (r_fill[gi_ix] == PCW'(MAX_POINTS)) begin
                        n_status = ST_FULL;
                        n_ovalid = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_ADD_DIV;
                    end
                end else begin
                    n_gi = r_gi + 1'b1;
                end
            end

            S_ADD_DIV: begin
                if (div_done) begin
                    ram_we = 1'b1;
                    if (div_quot[DW-1:DATA_W] != '0) begin
                        ram_wdata = {r_s, {DATA_W{1'b1}}};
                    end else begin
                        ram_wdata = {r_s, div_quot[DATA_W-1:0]};
                    end
                    fill_we  = 1'b1;
                    fill_wd  = r_fill[gi_ix] + 1'b1;
                    n_status = ST_OK;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_Q_GSCN: begin
                if (r_gi == r_total) begin
                    if (!r_lo_has && !r_hi_has) begin
                        n_factor = '0;
                        n_status = ST_OK;
                        n_ovalid = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_cur    = r_lo_has ? r_lo_idx : r_hi_idx;
                        n_second = 1'b0;
                        n_pi     = '0;
                        n_lhas   = 1'b0;
                        n_uhas   = 1'b0;
                        n_state  = S_Q_PRD;
                    end
                end else begin
                    if (r_key[gi_ix] <= r_n) begin
                        if (!r_lo_has || r_key[gi_ix] > r_lo_key) begin
                            n_lo_has = 1'b1;
                            n_lo_idx = gi_ix;
                            n_lo_key = r_key[gi_ix];
                        end
                    end else if (!r_hi_has || r_key[gi_ix] < r_hi_key) begin
                        n_hi_has = 1'b1;
                        n_hi_idx = gi_ix;
                        n_hi_key = r_key[gi_ix];
                    end
                    n_gi = r_gi + 1'b1;
                end
            end

            S_Q_PRD: begin
                if (r_pi == cur_fill) begin
                    n_state = S_Q_GEND;
                end else begin
                    n_state = S_Q_PCMP;
                end
            end

            S_Q_PCMP: begin
                // lower neighbor: largest size not above, latest on ties
                if (rd_size <= r_s) begin
                    if (!r_lhas || rd_size >= r_ls) begin
                        n_lhas = 1'b1;
                        n_ls   = rd_size;
                        n_lf   = rd_fac;
                    end
                end else if (!r_uhas || rd_size < r_us) begin
                    n_uhas = 1'b1;
                    n_us   = rd_size;
                    n_uf   = rd_fac;
                end
                n_pi    = r_pi + 1'b1;
                n_state = S_Q_PRD;
            end

            S_Q_GEND: begin
                if (!r_lhas && !r_uhas) begin
                    gv_fire = 1'b1;
                    gv_val  = '0;
                end else if (!r_lhas) begin
                    gv_fire = 1'b1;
                    gv_val  = r_uf;
                end else if (!r_uhas) begin
                    gv_fire = 1'b1;
                    gv_val  = r_lf;
                end else begin
                    n_fl      = r_lf;
                    n_fu      = r_uf;
                    n_outer   = 1'b0;
                    div_start = 1'b1;
                    div_dvd   = {r_s - r_ls, FRAC_BITS'(0)};
                    div_dvs   = r_us - r_ls;
                    n_state   = S_B_DIV;
                end
            end

            S_B_DIV: begin
                n_up   = (r_fu >= r_fl);
                n_diff = (r_fu >= r_fl) ? (r_fu - r_fl) : (r_fl - r_fu);
                if (div_done) begin
                    n_state = S_B_MUL;
                end
            end

            S_B_MUL: begin
                n_prod  = PW'(r_diff) * PW'(div_quot[PERCW-1:0]);
                n_state = S_B_ADD;
            end

            S_B_ADD: begin
                if (r_outer) begin
                    n_factor = blend_res;
                    n_status = ST_OK;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    gv_fire = 1'b1;
                    gv_val  = blend_res;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a group value is ready: go on to the second group or finish
        if (gv_fire) begin
            if (!r_second && r_lo_has && r_hi_has) begin
                n_vlo    = gv_val;
                n_cur    = r_hi_idx;
                n_second = 1'b1;
                n_pi     = '0;
                n_lhas   = 1'b0;
                n_uhas   = 1'b0;
                n_state  = S_Q_PRD;
            end else if (r_second) begin
                n_fl      = r_vlo;
                n_fu      = gv_val;
                n_outer   = 1'b1;
                div_start = 1'b1;
                div_dvd   = {DATA_W'(r_n - r_lo_key), FRAC_BITS'(0)};
                div_dvs   = DATA_W'(r_hi_key - r_lo_key);
                n_state   = S_B_DIV;
            end else begin
                n_factor = gv_val;
                n_status = ST_OK;
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cal    <= 1'b0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cal    <= n_cal;
            r_total  <= n_total;
            r_ovalid <= n_ovalid;
        end
    end

    // fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_GROUPS; i++) begin
                r_fill[i] <= '0;
            end
        end else if (fill_we) begin
            r_fill[grp_wi] <= fill_wd;
        end
    end

    // group keys, written before read
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key[grp_wi] <= key_wd;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_n   <= i_input_count;
            r_s   <= i_size_value;
            r_m   <= i_measured_power;
            r_e   <= i_estimated_power;
        end
        r_factor <= n_factor;
        r_status <= n_status;
        r_gi     <= n_gi;
        r_pi     <= n_pi;
        r_cur    <= n_cur;
        r_second <= n_second;
        r_lo_has <= n_lo_has;
        r_lo_idx <= n_lo_idx;
        r_lo_key <= n_lo_key;
        r_hi_has <= n_hi_has;
        r_hi_idx <= n_hi_idx;
        r_hi_key <= n_hi_key;
        r_lhas   <= n_lhas;
        r_ls     <= n_ls;
        r_lf     <= n_lf;
        r_uhas   <= n_uhas;
        r_us     <= n_us;
        r_uf     <= n_uf;
        r_outer  <= n_outer;
        r_fl     <= n_fl;
        r_fu     <= n_fu;
        r_diff   <= n_diff;
        r_up     <= n_up;
        r_prod   <= n_prod;
        r_vlo    <= n_vlo;
    end

    // busy covers the whole request; the strobe cycle is already idle
    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_factor_out = r_factor;
    assign o_status     = r_status;

endmodule

[hdl/cfbt_ram.sv]
// ----------------------------------------------------------------------------
// cfbt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module cfbt_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/cfbt_div.sv]
// ----------------------------------------------------------------------------
// cfbt_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cfbt_div
    import cfbt_pkg::*;
#(
    parameter int DW = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DW-1:0]     i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DW-1:0]     o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_done, n_done;
    logic [DW-1:0]     r_q, n_q;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_den, n_den;
    logic [DATA_W:0]   trial;

    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        trial  = {r_rem, r_q[DW-1]};
        if (i_start) begin
            n_cnt = CW'(DW);
            n_q   = i_dividend;
            n_rem = '0;
            n_den = i_divisor;
        end else if (r_cnt != '0) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = DATA_W'(trial - {1'b0, r_den});
                n_q   = {r_q[DW-2:0], 1'b1};
            end else begin
                n_rem = trial[DATA_W-1:0];
                n_q   = {r_q[DW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
